>>> hw/rtl/pgtbl_pkg.sv
// Shared sizes, codes and types of the two-level page table manager.
package pgtbl_pkg;

    // Sizes of the directories and of the page table pool.
    localparam int NUM_DIRECTORIES   = 4;
    localparam int NUM_TABLES        = 16;
    localparam int ENTRIES_PER_LEVEL = 1024;

    localparam int IDX_W    = $clog2(ENTRIES_PER_LEVEL);
    localparam int DID_W    = (NUM_DIRECTORIES > 1) ? $clog2(NUM_DIRECTORIES) : 1;
    localparam int TIDX_W   = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int CNT_W    = $clog2(NUM_TABLES + 1);

    localparam int DIR_DEPTH  = NUM_DIRECTORIES * ENTRIES_PER_LEVEL;
    localparam int DIR_AW     = DID_W + IDX_W;
    localparam int POOL_DEPTH = NUM_TABLES * ENTRIES_PER_LEVEL;
    localparam int POOL_AW    = TIDX_W + IDX_W;

    // The clearing pass after reset sweeps the larger of the two stores.
    localparam int CLR_DEPTH = (POOL_DEPTH > DIR_DEPTH) ? POOL_DEPTH : DIR_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] FRAME_MASK    = 32'hFFFF_F000;
    localparam logic [11:0] FLAG_PRESENT  = 12'h001;
    localparam int          FLAG_USER_BIT = 2;

    typedef enum logic [1:0] {
        CMD_MAP    = 2'd0,
        CMD_UNMAP  = 2'd1,
        CMD_LOOKUP = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_TABLE    = 2'd1,
        ST_NOT_PRESENT = 2'd2
    } t_status;

    // Operation class decided by the front.
    typedef enum logic [2:0] {
        K_MAP,
        K_UNMAP,
        K_LOOKUP,
        K_IGNORE,
        K_BAD_DIR
    } t_kind;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_DIR,
        BS_POOL
    } t_back_state;

    typedef struct packed {
        t_kind              kind;
        logic [DIR_AW-1:0]  dir_addr;
        logic [IDX_W-1:0]   pt_idx;
        logic [31:0]        entry;
        logic               user;
        logic [31:0]        virt_addr;
    } t_op;

    typedef struct packed {
        logic               present;
        logic               user;
        logic [TIDX_W-1:0]  table_idx;
    } t_dir_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> hw/rtl/pgtbl_ifs.sv
// Handshake interfaces of the command channel and the result channel.
interface pgtbl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [1:0]  dir_id;
    logic [31:0] virt_addr;
    logic [31:0] page_addr;
    logic [11:0] page_flags;

    modport source (output valid, cmd, dir_id, virt_addr, page_addr, page_flags,
                    input ready);
    modport sink   (input valid, cmd, dir_id, virt_addr, page_addr, page_flags,
                    output ready);
endinterface

interface pgtbl_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] phys_frame;
    logic        tlb_invalidate;
    logic [31:0] invalidate_addr;

    modport source (output valid, status, phys_frame, tlb_invalidate, invalidate_addr,
                    input ready);
    modport sink   (input valid, status, phys_frame, tlb_invalidate, invalidate_addr,
                    output ready);
endinterface

>>> hw/rtl/pgtbl_front.sv
// Front end: takes command beats and classifies them into queue entries.
module pgtbl_front (
    pgtbl_req_if.sink           i_req,
    input  logic                i_clearing,
    input  pgtbl_pkg::t_q_stat  i_q_stat,
    output logic                o_push,
    output pgtbl_pkg::t_op      o_op
);

    // Directory store address: directory number above the directory index.
    function automatic logic [pgtbl_pkg::DIR_AW-1:0] dir_address(
        input logic [1:0]                  dir_id,
        input logic [pgtbl_pkg::IDX_W-1:0] pd
    );
        logic [31:0] wide;
        wide = (32'(dir_id) << pgtbl_pkg::IDX_W) | 32'(pd);
        return wide[pgtbl_pkg::DIR_AW-1:0];
    endfunction

    logic in_range;

    // Beats are refused while the stores are being cleared or the queue is full.
    assign i_req.ready = !i_clearing && !i_q_stat.full;
    assign o_push      = i_req.valid && i_req.ready;

    assign in_range = 32'(i_req.dir_id) < pgtbl_pkg::NUM_DIRECTORIES;

    always_comb begin
        // Classify the command; an unknown code is answered without touching state.
        case (pgtbl_pkg::t_cmd'(i_req.cmd))
            pgtbl_pkg::CMD_MAP: begin
                o_op.kind = in_range ? pgtbl_pkg::K_MAP : pgtbl_pkg::K_BAD_DIR;
            end
            pgtbl_pkg::CMD_UNMAP: begin
                o_op.kind = in_range ? pgtbl_pkg::K_UNMAP : pgtbl_pkg::K_BAD_DIR;
            end
            pgtbl_pkg::CMD_LOOKUP: begin
                o_op.kind = in_range ? pgtbl_pkg::K_LOOKUP : pgtbl_pkg::K_BAD_DIR;
            end
            default: begin
                o_op.kind = pgtbl_pkg::K_IGNORE;
            end
        endcase

        // Split the virtual address and build the table entry for a map.
        o_op.dir_addr  = dir_address(i_req.dir_id,
                                     i_req.virt_addr[31 -: pgtbl_pkg::IDX_W]);
        o_op.pt_idx    = i_req.virt_addr[21 -: pgtbl_pkg::IDX_W];
        o_op.entry     = i_req.page_addr | {20'b0, i_req.page_flags}
                       | {20'b0, pgtbl_pkg::FLAG_PRESENT};
        o_op.user      = i_req.page_flags[pgtbl_pkg::FLAG_USER_BIT];
        o_op.virt_addr = i_req.virt_addr;
    end

endmodule

>>> hw/rtl/pgtbl_queue.sv
// Short FIFO of classified operations between the front and the back.
module pgtbl_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pgtbl_pkg::t_op      i_op,
    input  logic                i_pop,
    output pgtbl_pkg::t_op      o_op,
    output pgtbl_pkg::t_q_stat  o_stat
);

    pgtbl_pkg::t_op                 r_mem [pgtbl_pkg::QUEUE_DEPTH];
    logic [pgtbl_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [pgtbl_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [pgtbl_pkg::QCNT_W-1:0]   r_count;
    logic [pgtbl_pkg::QPTR_W-1:0]   n_wr_ptr;
    logic [pgtbl_pkg::QPTR_W-1:0]   n_rd_ptr;

    // Pointer advance with wrap at the queue depth.
    always_comb begin
        n_wr_ptr = (r_wr_ptr == pgtbl_pkg::QPTR_W'(pgtbl_pkg::QUEUE_DEPTH - 1))
                 ? '0 : r_wr_ptr + pgtbl_pkg::QPTR_W'(1);
        n_rd_ptr = (r_rd_ptr == pgtbl_pkg::QPTR_W'(pgtbl_pkg::QUEUE_DEPTH - 1))
                 ? '0 : r_rd_ptr + pgtbl_pkg::QPTR_W'(1);
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + pgtbl_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - pgtbl_pkg::QCNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    assign o_op   = r_mem[r_rd_ptr];
    assign o_stat = '{full:  (r_count == pgtbl_pkg::QCNT_W'(pgtbl_pkg::QUEUE_DEPTH)),
                      empty: (r_count == '0)};

endmodule

>>> hw/rtl/pgtbl_back.sv
// Back end: holds the directory store and table pool and carries out operations.
module pgtbl_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pgtbl_pkg::t_op      i_op,
    input  pgtbl_pkg::t_q_stat  i_q_stat,
    output logic                o_pop,
    output logic                o_clearing,
    pgtbl_rsp_if.source         o_rsp
);

    // Stores.
    pgtbl_pkg::t_dir_entry  r_dir_mem  [pgtbl_pkg::DIR_DEPTH];
    logic [31:0]            r_pool_mem [pgtbl_pkg::POOL_DEPTH];

    pgtbl_pkg::t_back_state         r_state;
    pgtbl_pkg::t_back_state         n_state;
    logic [pgtbl_pkg::CLR_W-1:0]    r_clr_cnt;
    logic [pgtbl_pkg::CNT_W-1:0]    r_next_free;
    pgtbl_pkg::t_op                 r_op;
    pgtbl_pkg::t_dir_entry          r_dir_q;
    logic [31:0]                    r_pool_q;

    logic                           r_out_valid;
    pgtbl_pkg::t_status             r_out_status;
    logic [31:0]                    r_out_frame;
    logic                           r_out_inv;
    logic [31:0]                    r_out_inv_addr;

    logic                           out_free;
    logic                           done;
    logic                           alloc;
    logic                           dir_we;
    logic [pgtbl_pkg::DIR_AW-1:0]   dir_wa;
    pgtbl_pkg::t_dir_entry          dir_wd;
    logic                           pool_we;
    logic [pgtbl_pkg::POOL_AW-1:0]  pool_wa;
    logic [31:0]                    pool_wd;
    logic                           pool_re;
    logic [pgtbl_pkg::POOL_AW-1:0]  pool_ra;
    logic [pgtbl_pkg::TIDX_W-1:0]   new_table;
    pgtbl_pkg::t_status             res_status;
    logic [31:0]                    res_frame;
    logic                           res_inv;
    logic [31:0]                    res_addr;

    assign out_free  = !r_out_valid || o_rsp.ready;
    assign new_table = pgtbl_pkg::TIDX_W'(r_next_free);
    assign pool_ra   = {r_dir_q.table_idx, r_op.pt_idx};

    // Sequencer: next state, store writes and the result of the current operation.
    always_comb begin
        n_state    = r_state;
        done       = 1'b0;
        alloc      = 1'b0;
        dir_we     = 1'b0;
        dir_wa     = r_op.dir_addr;
        dir_wd     = '0;
        pool_we    = 1'b0;
        pool_wa    = {r_dir_q.table_idx, r_op.pt_idx};
        pool_wd    = '0;
        pool_re    = 1'b0;
        res_status = pgtbl_pkg::ST_OK;
        res_frame  = '0;
        res_inv    = 1'b0;
        res_addr   = '0;

        case (r_state)
            pgtbl_pkg::BS_CLEAR: begin
                dir_wa  = pgtbl_pkg::DIR_AW'(r_clr_cnt);
                pool_wa = pgtbl_pkg::POOL_AW'(r_clr_cnt);
                dir_we  = 32'(r_clr_cnt) < pgtbl_pkg::DIR_DEPTH;
                pool_we = 32'(r_clr_cnt) < pgtbl_pkg::POOL_DEPTH;
                if (r_clr_cnt == pgtbl_pkg::CLR_W'(pgtbl_pkg::CLR_DEPTH - 1)) begin
                    n_state = pgtbl_pkg::BS_IDLE;
                end
            end
            pgtbl_pkg::BS_IDLE: begin
                n_state = pgtbl_pkg::BS_IDLE;
            end
            pgtbl_pkg::BS_DIR: begin
                if (out_free) begin
                    case (r_op.kind)
                        pgtbl_pkg::K_MAP: begin
                            done = 1'b1;
                            if (r_dir_q.present) begin
                                pool_we = 1'b1;
                                pool_wd = r_op.entry;
                            end else if (32'(r_next_free) >= pgtbl_pkg::NUM_TABLES) begin
                                res_status = pgtbl_pkg::ST_NO_TABLE;
                            end else begin
                                alloc            = 1'b1;
                                dir_we           = 1'b1;
                                dir_wd.present   = 1'b1;
                                dir_wd.user      = r_op.user;
                                dir_wd.table_idx = new_table;
                                pool_we          = 1'b1;
                                pool_wa          = {new_table, r_op.pt_idx};
                                pool_wd          = r_op.entry;
                            end
                        end
                        pgtbl_pkg::K_UNMAP: begin
                            done = 1'b1;
                            if (r_dir_q.present) begin
                                pool_we  = 1'b1;
                                res_inv  = 1'b1;
                                res_addr = r_op.virt_addr;
                            end else begin
                                res_status = pgtbl_pkg::ST_NOT_PRESENT;
                            end
                        end
                        pgtbl_pkg::K_LOOKUP: begin
                            if (r_dir_q.present) begin
                                pool_re = 1'b1;
                                n_state = pgtbl_pkg::BS_POOL;
                            end else begin
                                done       = 1'b1;
                                res_status = pgtbl_pkg::ST_NOT_PRESENT;
                            end
                        end
                        pgtbl_pkg::K_BAD_DIR: begin
                            done       = 1'b1;
                            res_status = pgtbl_pkg::ST_NOT_PRESENT;
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            pgtbl_pkg::BS_POOL: begin
                if (out_free) begin
                    done      = 1'b1;
                    res_frame = r_pool_q & pgtbl_pkg::FRAME_MASK;
                end
            end
            default: begin
                n_state = pgtbl_pkg::BS_IDLE;
            end
        endcase

        // Take the next operation as soon as the current one has finished.
        o_pop = !i_q_stat.empty && ((r_state == pgtbl_pkg::BS_IDLE) || done);
        if (o_pop) begin
            n_state = pgtbl_pkg::BS_DIR;
        end else if (done) begin
            n_state = pgtbl_pkg::BS_IDLE;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pgtbl_pkg::BS_CLEAR;
            r_clr_cnt   <= '0;
            r_next_free <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pgtbl_pkg::BS_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + pgtbl_pkg::CLR_W'(1);
            end
            if (alloc) begin
                r_next_free <= r_next_free + pgtbl_pkg::CNT_W'(1);
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Current operation and the result register.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_op;
        end
        if (done) begin
            r_out_status   <= res_status;
            r_out_frame    <= res_frame;
            r_out_inv      <= res_inv;
            r_out_inv_addr <= res_addr;
        end
    end

    // Directory store; a write in the same cycle as a read of that entry is forwarded.
    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            r_dir_mem[dir_wa] <= dir_wd;
        end
        if (o_pop) begin
            if (dir_we && (dir_wa == i_op.dir_addr)) begin
                r_dir_q <= dir_wd;
            end else begin
                r_dir_q <= r_dir_mem[i_op.dir_addr];
            end
        end
    end

    // Table pool.
    always_ff @(posedge i_clk) begin
        if (pool_we) begin
            r_pool_mem[pool_wa] <= pool_wd;
        end
        if (pool_re) begin
            r_pool_q <= r_pool_mem[pool_ra];
        end
    end

    assign o_clearing            = r_state == pgtbl_pkg::BS_CLEAR;
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.phys_frame      = r_out_frame;
    assign o_rsp.tlb_invalidate  = r_out_inv;
    assign o_rsp.invalidate_addr = r_out_inv_addr;

endmodule

>>> hw/rtl/two_level_page_table_manager.sv
// Top level of the two-level page table manager: front, queue and back joined.
//
//  Channel  Dir  Beat carries                                        Accepted when
//  i_req    in   cmd, dir_id, virt_addr, page_addr, page_flags       valid && ready
//  o_rsp    out  status, phys_frame, tlb_invalidate, invalidate_addr valid && ready
//
// A command is written into the queue at the edge that takes it; the back pops it once the
// queue's fill level shows it and the back is idle or finishing. Map and unmap finish after
// the directory read, lookup after the directory read and then a pool read, and each result
// is registered. The back pops the next command in the cycle that finishes the current
// one, so while o_rsp is not stalled map and unmap complete one per cycle; a lookup holds
// the back through its pool read. After reset a clearing pass over the larger of the two
// stores zeroes both, with i_req.ready held low.
// A stalled o_rsp holds its beat; three further commands can be taken behind it,
// one held in the back and two in the queue.
module two_level_page_table_manager (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pgtbl_req_if.sink   i_req,
    pgtbl_rsp_if.source o_rsp
);

    logic                   push;
    logic                   pop;
    logic                   clearing;
    pgtbl_pkg::t_op         front_op;
    pgtbl_pkg::t_op         queue_op;
    pgtbl_pkg::t_q_stat     q_stat;

    // Classification of incoming commands.
    pgtbl_front u_front (
        .i_req      (i_req),
        .i_clearing (clearing),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_op       (front_op)
    );

    // Decoupling queue.
    pgtbl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_op    (queue_op),
        .o_stat  (q_stat)
    );

    // Store access and results.
    pgtbl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (queue_op),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_rsp      (o_rsp)
    );

endmodule

>>> hw/rtl/pgtbl_checker.sv
// Port-level checks of the page table manager, bound to the top level.
module pgtbl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_rsp_status,
    input logic [31:0] i_rsp_frame,
    input logic        i_rsp_inv,
    input logic [31:0] i_rsp_inv_addr
);

    // A stalled result beat stays put.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_frame) && $stable(i_rsp_inv) && $stable(i_rsp_inv_addr))
        else $error("result beat changed while stalled");

    // No command is taken in the first cycle after reset, while the stores are cleared.
    a_clear_first: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !i_req_ready)
        else $error("command accepted before the clearing pass");

    // An invalidate only comes with a successful result.
    a_inv_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_inv |-> i_rsp_status == pgtbl_pkg::ST_OK)
        else $error("invalidate on a failed command");

    // Without an invalidate the address field is zero.
    a_inv_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_inv |-> i_rsp_inv_addr == 32'd0)
        else $error("invalidate address set without invalidate");

    // A frame never carries flag bits, and a failure carries no frame.
    a_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_frame[11:0] == 12'd0
            && (i_rsp_status == pgtbl_pkg::ST_OK || i_rsp_frame == 32'd0))
        else $error("bad physical frame in result");

endmodule

bind two_level_page_table_manager pgtbl_checker u_pgtbl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_status   (o_rsp.status),
    .i_rsp_frame    (o_rsp.phys_frame),
    .i_rsp_inv      (o_rsp.tlb_invalidate),
    .i_rsp_inv_addr (o_rsp.invalidate_addr)
);
